// ===== rtl/fch_pkg.sv =====
// Shared types, register codes and reset constants for the fan curve governor.
package fch_pkg;

	localparam int NUM_BP = 5;
	localparam int DIV_STEPS = 16;

	typedef logic [7:0] temp_t;
	typedef temp_t bp_array_t [0:NUM_BP-1];

	typedef enum logic [2:0] {
		REG_TEMP_SILENT = 3'd0,
		REG_TEMP_LOW    = 3'd1,
		REG_TEMP_MED    = 3'd2,
		REG_TEMP_HIGH   = 3'd3,
		REG_TEMP_TOP    = 3'd4,
		REG_HYST_MARGIN = 3'd5,
		REG_SPEED_TABLE = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		TREND_FIRST  = 2'd0,
		TREND_RISING = 2'd1,
		TREND_FALL   = 2'd2,
		TREND_STEADY = 2'd3
	} trend_t;

	localparam logic [7:0]  RST_TEMP_SILENT = 8'd62;
	localparam logic [7:0]  RST_TEMP_LOW    = 8'd70;
	localparam logic [7:0]  RST_TEMP_MED    = 8'd78;
	localparam logic [7:0]  RST_TEMP_HIGH   = 8'd86;
	localparam logic [7:0]  RST_TEMP_TOP    = 8'd92;
	localparam logic [5:0]  RST_HYST_MARGIN = 6'd6;
	localparam logic [39:0] RST_SPEED_TABLE = 40'd861516608025;

	typedef struct packed {
		logic [7:0] cpu_sensor_temp;
		logic [7:0] gpu_sensor_temp;
		logic [7:0] ec_sensor_temp;
		logic [7:0] fan_a_speed;
		logic [7:0] fan_b_speed;
	} poll_t;

	typedef struct packed {
		logic [7:0] target_speed;
		logic [7:0] cpu_temp_used;
		logic [7:0] gpu_temp_used;
		trend_t     trend;
	} result_t;

	typedef struct packed {
		cfg_reg_t    index;
		logic [39:0] data;
	} cfg_t;

	// Request to and response from the shared curve unit.
	typedef struct packed {
		logic       start;
		logic [8:0] temp;
	} curve_req_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] speed;
	} curve_rsp_t;

endpackage

// ===== rtl/fch_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
interface fch_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/fch_curve.sv =====
// Piecewise-linear curve unit: segment select, multiply, bit-serial divide.
module fch_curve import fch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  curve_req_t req,
	input  bp_array_t  bp,
	input  bp_array_t  speed,
	output curve_rsp_t rsp
);

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_MUL  = 4'b0010,
		C_DIV  = 4'b0100,
		C_DONE = 4'b1000
	} cstate_t;

	cstate_t     state_q;
	logic        direct_q;
	logic        neg_q;
	logic [7:0]  speed_q;
	logic [7:0]  lo_q;
	logic [7:0]  hi_q;
	logic [7:0]  pos_q;
	logic [7:0]  width_q;
	logic [15:0] dvd_q;
	logic [7:0]  rem_q;
	logic [3:0]  cnt_q;

	logic        below_first;
	logic        seg_found;
	logic [2:0]  seg_k;
	logic [2:0]  lo_idx;
	logic [7:0]  mag;
	logic [8:0]  shifted;

	// Pick the first breakpoint at or above the temperature.
	always_comb begin
		below_first = (req.temp <= {1'b0, bp[0]});
		seg_found = 1'b0;
		seg_k = 3'd0;
		for (int k = 1; k < NUM_BP; k++) begin
			if (!seg_found && req.temp <= {1'b0, bp[k]}) begin
				seg_found = 1'b1;
				seg_k = 3'(k);
			end
		end
		lo_idx = seg_found ? seg_k - 3'd1 : 3'd0;
	end

	assign mag = (hi_q < lo_q) ? lo_q - hi_q : hi_q - lo_q;
	assign shifted = {rem_q, dvd_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						if (below_first || !seg_found) begin
							state_q <= C_DONE;
						end else begin
							state_q <= C_MUL;
						end
					end
				end
				C_MUL: begin
					cnt_q <= '0;
					state_q <= C_DIV;
				end
				C_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(DIV_STEPS - 1)) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && req.start) begin
			direct_q <= below_first || !seg_found;
			speed_q <= below_first ? speed[0] : speed[NUM_BP-1];
			lo_q <= speed[lo_idx];
			hi_q <= speed[seg_k];
			pos_q <= req.temp[7:0] - bp[lo_idx];
			width_q <= bp[seg_k] - bp[lo_idx];
		end
		if (state_q == C_MUL) begin
			neg_q <= hi_q < lo_q;
			dvd_q <= mag * pos_q;
			rem_q <= '0;
		end
		// Restoring division: one quotient bit per cycle, shifted in at the bottom.
		if (state_q == C_DIV) begin
			if (shifted >= {1'b0, width_q}) begin
				rem_q <= 8'(shifted - {1'b0, width_q});
				dvd_q <= {dvd_q[14:0], 1'b1};
			end else begin
				rem_q <= shifted[7:0];
				dvd_q <= {dvd_q[14:0], 1'b0};
			end
		end
	end

	assign rsp.busy = (state_q != C_IDLE);
	assign rsp.done = (state_q == C_DONE);
	assign rsp.speed = direct_q ? speed_q :
		(neg_q ? lo_q - dvd_q[7:0] : lo_q + dvd_q[7:0]);

endmodule

// ===== rtl/fan_curve_hysteresis.sv =====
// Fan speed governor: sensor fallback, curve lookup with step-down hysteresis, trend.
// Each poll transaction yields one result transaction. A curve pass skips the multiply and
// divide at the curve ends and runs the multiply and a 16-step divider inside a segment.
// The curve unit runs once, or twice when the step-down test is needed; one poll at a time,
// so a new poll is taken only after the previous result is loaded, and may be taken while it waits.
// Reset (arst_n low) restores the register defaults and clears the previous-target state.
module fan_curve_hysteresis import fch_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fch_chan_if.sink   poll,
	fch_chan_if.source result,
	fch_chan_if.sink   cfg
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_GO1   = 6'b000010,
		S_WAIT1 = 6'b000100,
		S_GO2   = 6'b001000,
		S_WAIT2 = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t      state_q;
	bp_array_t   bp_q;
	logic [5:0]  margin_q;
	logic [39:0] speed_tbl_q;
	logic [7:0]  cpu_q;
	logic [7:0]  gpu_q;
	logic [7:0]  hot_q;
	logic [7:0]  cur_q;
	logic [7:0]  target_q;
	logic        have_prev_q;
	logic [7:0]  last_q;
	logic        res_valid_q;
	result_t     res_q;

	bp_array_t   speeds;
	curve_req_t  creq;
	curve_rsp_t  crsp;
	logic [7:0]  cpu_t;
	logic [7:0]  gpu_t;
	logic [7:0]  hot_t;
	logic [8:0]  fan_sum;
	logic        load;
	trend_t      trend_n;

	always_comb begin
		for (int i = 0; i < NUM_BP; i++) begin
			speeds[i] = speed_tbl_q[8*i +: 8];
		end
	end

	// Sensor fallback: CPU, else EC, else GPU; GPU falls back to the chosen CPU value.
	always_comb begin
		priority if (poll.payload.cpu_sensor_temp != 8'd0) begin
			cpu_t = poll.payload.cpu_sensor_temp;
		end else if (poll.payload.ec_sensor_temp != 8'd0) begin
			cpu_t = poll.payload.ec_sensor_temp;
		end else begin
			cpu_t = poll.payload.gpu_sensor_temp;
		end
		gpu_t = (poll.payload.gpu_sensor_temp != 8'd0) ? poll.payload.gpu_sensor_temp : cpu_t;
		hot_t = (cpu_t > gpu_t) ? cpu_t : gpu_t;
		fan_sum = {1'b0, poll.payload.fan_a_speed} + {1'b0, poll.payload.fan_b_speed};
	end

	assign creq.start = (state_q == S_GO1) || (state_q == S_GO2);
	assign creq.temp = (state_q == S_GO2) ? {1'b0, hot_q} + {3'b000, margin_q} : {1'b0, hot_q};

	fch_curve u_curve (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.bp     (bp_q),
		.speed  (speeds),
		.rsp    (crsp)
	);

	assign poll.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	always_comb begin
		priority if (!have_prev_q) begin
			trend_n = TREND_FIRST;
		end else if (target_q > last_q) begin
			trend_n = TREND_RISING;
		end else if (target_q < last_q) begin
			trend_n = TREND_FALL;
		end else begin
			trend_n = TREND_STEADY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q[0] <= RST_TEMP_SILENT;
			bp_q[1] <= RST_TEMP_LOW;
			bp_q[2] <= RST_TEMP_MED;
			bp_q[3] <= RST_TEMP_HIGH;
			bp_q[4] <= RST_TEMP_TOP;
			margin_q <= RST_HYST_MARGIN;
			speed_tbl_q <= RST_SPEED_TABLE;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				REG_TEMP_SILENT: bp_q[0] <= cfg.payload.data[7:0];
				REG_TEMP_LOW:    bp_q[1] <= cfg.payload.data[7:0];
				REG_TEMP_MED:    bp_q[2] <= cfg.payload.data[7:0];
				REG_TEMP_HIGH:   bp_q[3] <= cfg.payload.data[7:0];
				REG_TEMP_TOP:    bp_q[4] <= cfg.payload.data[7:0];
				REG_HYST_MARGIN: margin_q <= cfg.payload.data[5:0];
				REG_SPEED_TABLE: speed_tbl_q <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			have_prev_q <= 1'b0;
			last_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				have_prev_q <= 1'b1;
				last_q <= target_q;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (poll.valid) state_q <= S_GO1;
				S_GO1:   state_q <= S_WAIT1;
				S_WAIT1: begin
					if (crsp.done) begin
						// Step down only if the curve at temperature plus margin agrees.
						state_q <= (crsp.speed < cur_q) ? S_GO2 : S_DONE;
					end
				end
				S_GO2:   state_q <= S_WAIT2;
				S_WAIT2: if (crsp.done) state_q <= S_DONE;
				S_DONE:  if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && poll.valid) begin
			cpu_q <= cpu_t;
			gpu_q <= gpu_t;
			hot_q <= hot_t;
			cur_q <= fan_sum[8:1];
		end
		if (state_q == S_WAIT1 && crsp.done) begin
			target_q <= crsp.speed;
		end
		if (state_q == S_WAIT2 && crsp.done && crsp.speed >= cur_q) begin
			target_q <= cur_q;
		end
		if (load) begin
			res_q.target_speed <= target_q;
			res_q.cpu_temp_used <= cpu_q;
			res_q.gpu_temp_used <= gpu_q;
			res_q.trend <= trend_n;
		end
	end

	assign result.valid = res_valid_q;
	assign result.payload = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		creq.start |-> !crsp.busy)
		else $error("curve unit started while busy");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		crsp.done |-> (state_q == S_WAIT1 || state_q == S_WAIT2))
		else $error("curve result arrived with no pass pending");

	a_last_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (last_q == result.payload.target_speed && result.valid))
		else $error("previous target differs from delivered target");

endmodule

// ===== sim/fan_curve_hysteresis_test.sv =====
// Self-checking testbench for the fan curve governor with step-down hysteresis.
module fan_curve_hysteresis_test;
	import fch_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 50;

	logic clk;
	logic arst_n;

	fch_chan_if #(.payload_t(poll_t))   poll_ch ();
	fch_chan_if #(.payload_t(result_t)) result_ch ();
	fch_chan_if #(.payload_t(cfg_t))    cfg_ch ();

	fan_curve_hysteresis u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Governor shadow: register copies and trend state
	logic [7:0]  bp_model [0:NUM_BP-1];
	logic [5:0]  margin_model;
	logic [39:0] speeds_model;
	bit          prev_valid;
	logic [7:0]  model_last_target;

	result_t pending_results [$];
	int      error_count;
	int      cycle_count;
	int      hold_cycles;
	bit      idle_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int table_speed(int k);
		return int'(speeds_model[8*k +: 8]);
	endfunction

	function automatic int curve_speed(int temp);
		int width;
		int pos;
		int lo;
		int hi;
		if (temp <= int'(bp_model[0]))
			return table_speed(0);
		for (int k = 1; k < NUM_BP; k++) begin
			if (temp <= int'(bp_model[k])) begin
				width = int'(bp_model[k]) - int'(bp_model[k-1]);
				pos = temp - int'(bp_model[k-1]);
				lo = table_speed(k - 1);
				hi = table_speed(k);
				if (width <= 0)
					return hi;
				return lo + ((hi - lo) * pos) / width;
			end
		end
		return table_speed(NUM_BP - 1);
	endfunction

	function automatic result_t governor_predict(poll_t p);
		result_t r;
		int cpu_t;
		int gpu_t;
		int hot;
		int current;
		int target;
		if (p.cpu_sensor_temp != 0)
			cpu_t = int'(p.cpu_sensor_temp);
		else if (p.ec_sensor_temp != 0)
			cpu_t = int'(p.ec_sensor_temp);
		else
			cpu_t = int'(p.gpu_sensor_temp);
		gpu_t = (p.gpu_sensor_temp != 0) ? int'(p.gpu_sensor_temp) : cpu_t;
		hot = (cpu_t > gpu_t) ? cpu_t : gpu_t;
		current = (int'(p.fan_a_speed) + int'(p.fan_b_speed)) / 2;
		target = curve_speed(hot);
		// hold the current speed unless the curve plus margin also lies below it
		if (target < current && curve_speed(hot + int'(margin_model)) >= current)
			target = current;
		target &= 'hFF;
		if (!prev_valid)
			r.trend = TREND_FIRST;
		else if (target > int'(model_last_target))
			r.trend = TREND_RISING;
		else if (target < int'(model_last_target))
			r.trend = TREND_FALL;
		else
			r.trend = TREND_STEADY;
		prev_valid = 1'b1;
		model_last_target = target[7:0];
		r.target_speed = target[7:0];
		r.cpu_temp_used = cpu_t[7:0];
		r.gpu_temp_used = gpu_t[7:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending, target", int'(got.target_speed), 0);
			return;
		end
		want = pending_results.pop_front();
		if (got.target_speed != want.target_speed)
			report_mismatch("target_speed", int'(got.target_speed),
				int'(want.target_speed));
		if (got.cpu_temp_used != want.cpu_temp_used)
			report_mismatch("cpu_temp_used", int'(got.cpu_temp_used),
				int'(want.cpu_temp_used));
		if (got.gpu_temp_used != want.gpu_temp_used)
			report_mismatch("gpu_temp_used", int'(got.gpu_temp_used),
				int'(want.gpu_temp_used));
		if (got.trend != want.trend)
			report_mismatch("trend", int'(got.trend), int'(want.trend));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			check_result(result_ch.payload);
	end

	// Result side: a long hold-off when one is set, and random stall bursts while idle_on is set
	initial begin
		int burst;
		burst = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_ch.ready = 1'b0;
			end else if (burst > 0) begin
				burst--;
				result_ch.ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(0, 5);
				result_ch.ready = 1'b0;
			end else begin
				result_ch.ready = 1'b1;
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_poll(input poll_t p);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			poll_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll_ch.valid = 1'b1;
		poll_ch.payload = p;
		do
			@(posedge clk);
		while (!poll_ch.ready);
		pending_results.push_back(governor_predict(p));
		@(negedge clk);
		poll_ch.valid = 1'b0;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [39:0] value);
		wait_drained();
		cfg_ch.valid = 1'b1;
		cfg_ch.payload.index = idx;
		cfg_ch.payload.data = value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_TEMP_SILENT: bp_model[0] = value[7:0];
			REG_TEMP_LOW:    bp_model[1] = value[7:0];
			REG_TEMP_MED:    bp_model[2] = value[7:0];
			REG_TEMP_HIGH:   bp_model[3] = value[7:0];
			REG_TEMP_TOP:    bp_model[4] = value[7:0];
			REG_HYST_MARGIN: margin_model = value[5:0];
			REG_SPEED_TABLE: speeds_model = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic write_curve(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [5:0] margin,
			input logic [39:0] speeds);
		write_reg(REG_TEMP_SILENT, {32'd0, b0});
		write_reg(REG_TEMP_LOW, {32'd0, b1});
		write_reg(REG_TEMP_MED, {32'd0, b2});
		write_reg(REG_TEMP_HIGH, {32'd0, b3});
		write_reg(REG_TEMP_TOP, {32'd0, b4});
		write_reg(REG_HYST_MARGIN, {34'd0, margin});
		write_reg(REG_SPEED_TABLE, speeds);
	endtask

	function automatic poll_t make_poll(int cpu, int gpu, int ec, int f1, int f2);
		poll_t p;
		p.cpu_sensor_temp = cpu[7:0];
		p.gpu_sensor_temp = gpu[7:0];
		p.ec_sensor_temp = ec[7:0];
		p.fan_a_speed = f1[7:0];
		p.fan_b_speed = f2[7:0];
		return p;
	endfunction

	// Mostly near a breakpoint, sometimes missing, sometimes anywhere
	function automatic logic [7:0] pick_temp();
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r < 3)
			return 8'($urandom_range(0, 255));
		v = int'(bp_model[$urandom_range(0, NUM_BP - 1)]) + int'($urandom_range(0, 20)) - 10;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic logic [7:0] pick_fan();
		int v;
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		// land near the last target so the step-down test matters
		v = int'(model_last_target) + int'($urandom_range(0, 40)) - 20;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	task automatic send_random_polls(input int count);
		poll_t p;
		repeat (count) begin
			p.cpu_sensor_temp = pick_temp();
			p.gpu_sensor_temp = pick_temp();
			p.ec_sensor_temp = pick_temp();
			p.fan_a_speed = pick_fan();
			p.fan_b_speed = pick_fan();
			send_poll(p);
		end
	endtask

	task automatic random_config(input int style);
		logic [7:0] v [0:NUM_BP-1];
		logic [7:0] t;
		logic [39:0] speeds;
		logic [5:0] margin;
		for (int i = 0; i < NUM_BP; i++)
			v[i] = 8'($urandom_range(0, 255));
		speeds = {8'($urandom_range(0, 255)), $urandom()};
		margin = 6'($urandom_range(0, 63));
		case (style)
			0: begin
				// ascending breakpoints
				for (int i = 0; i < NUM_BP - 1; i++)
					for (int j = 0; j < NUM_BP - 1 - i; j++)
						if (v[j] > v[j+1]) begin
							t = v[j];
							v[j] = v[j+1];
							v[j+1] = t;
						end
			end
			1: ;
			2: begin
				t = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
				for (int i = 0; i < NUM_BP; i++)
					v[i] = t;
				margin = ($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0;
				speeds = ($urandom_range(0, 1) != 0) ? '1 : '0;
			end
			default: begin
				v[0] = RST_TEMP_SILENT;
				v[1] = RST_TEMP_LOW;
				v[2] = RST_TEMP_MED;
				v[3] = RST_TEMP_HIGH;
				v[4] = RST_TEMP_TOP;
				margin = RST_HYST_MARGIN;
				speeds = RST_SPEED_TABLE;
			end
		endcase
		write_curve(v[0], v[1], v[2], v[3], v[4], margin, speeds);
	endtask

	task automatic test_default_curve();
		idle_on = 1'b1;
		send_poll(make_poll(0, 0, 0, 0, 0));        // no sensor at all
		send_poll(make_poll(0, 0, 75, 10, 10));     // CPU from EC
		send_poll(make_poll(0, 80, 0, 10, 10));     // CPU from GPU
		send_poll(make_poll(90, 0, 50, 10, 10));    // GPU from CPU
		send_poll(make_poll(255, 255, 255, 255, 255));
		send_poll(make_poll(62, 0, 0, 0, 0));
		send_poll(make_poll(92, 0, 0, 0, 0));
		send_poll(make_poll(93, 0, 0, 0, 0));
		send_poll(make_poll(70, 40, 0, 60, 60));    // hold at current speed
		send_poll(make_poll(62, 0, 0, 100, 100));   // step down past margin
		send_poll(make_poll(62, 0, 0, 100, 100));
		send_poll(make_poll(64, 1, 1, 255, 254));   // odd fan sum
	endtask

	task automatic test_extreme_curves();
		write_curve(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd63, 40'hFF_00_80_40_01);
		send_poll(make_poll(0, 0, 0, 0, 0));
		send_poll(make_poll(1, 0, 0, 255, 255));
		send_poll(make_poll(255, 0, 0, 0, 0));
		send_poll(make_poll(0, 0, 255, 200, 100));
		write_curve(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 6'd63, 40'h00_32_64_96_C8);
		send_poll(make_poll(254, 0, 0, 0, 0));
		send_poll(make_poll(255, 0, 0, 255, 255));
		send_poll(make_poll(128, 0, 0, 255, 255));
		send_poll(make_poll(0, 0, 0, 255, 255));
		// unordered breakpoints with a falling table and a top breakpoint of 255
		write_curve(8'd100, 8'd50, 8'd150, 8'd120, 8'd255, 6'd0, 40'h00_40_80_C0_FF);
		send_poll(make_poll(75, 0, 0, 0, 0));
		send_poll(make_poll(125, 0, 0, 0, 0));
		send_poll(make_poll(160, 0, 0, 200, 200));
		send_poll(make_poll(250, 0, 0, 255, 255));
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 8; phase++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			random_config(phase % 4);
			send_random_polls(80);
		end
	endtask

	task automatic test_output_stall();
		idle_on = 1'b1;
		random_config(0);
		@(negedge clk);
		hold_cycles = 200;
		send_random_polls(30);
	endtask

	task automatic test_drain_pause();
		send_random_polls(20);
		wait_drained();
		send_random_polls(20);
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		random_config(1);
		send_random_polls(80);
	endtask

	initial begin
		arst_n = 1'b0;
		poll_ch.valid = 1'b0;
		poll_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		error_count = 0;
		cycle_count = 0;
		hold_cycles = 0;
		idle_on = 1'b0;
		bp_model[0] = RST_TEMP_SILENT;
		bp_model[1] = RST_TEMP_LOW;
		bp_model[2] = RST_TEMP_MED;
		bp_model[3] = RST_TEMP_HIGH;
		bp_model[4] = RST_TEMP_TOP;
		margin_model = RST_HYST_MARGIN;
		speeds_model = RST_SPEED_TABLE;
		prev_valid = 1'b0;
		model_last_target = 8'd0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_curve();
		test_extreme_curves();
		test_random_settings();
		test_output_stall();
		test_drain_pause();
		test_no_idle();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
